### src/triggered_sample_player_unit_assert.svh
// Assertion macros for the sample player.
// TSP_ASSERT checks a property while out of reset; TSP_ASSERT_NR also runs during reset.
`ifndef TRIGGERED_SAMPLE_PLAYER_UNIT_ASSERT_SVH
`define TRIGGERED_SAMPLE_PLAYER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TSP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sample player check failed");
`define TSP_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sample player reset check failed");
`else
`define TSP_ASSERT(label, clk, rst_n, prop)
`define TSP_ASSERT_NR(label, clk, prop)
`endif

`endif

### src/tsp_pkg.sv
package tsp_pkg;

    localparam int SLOT_BYTES = 4096;
    localparam int SLOT_COUNT = 7;
    localparam int MEM_DEPTH  = SLOT_BYTES * SLOT_COUNT;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int OP_W       = 2;
    localparam int SEL_W      = 3;
    localparam int LADDR_W    = 12;
    localparam int LEN_W      = 13;
    localparam int PHASE_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int INT_W      = PHASE_W - FRAC_W;
    localparam int SAMPLE_W   = 8;
    localparam int AUDIO_W    = 16;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // a * (1.0 - f) needs one bit above the fraction
    localparam int PA_W        = SAMPLE_W + FRAC_W + 1;
    localparam int PB_W        = SAMPLE_W + FRAC_W;
    localparam int INTERP_SHIFT = 8;

    localparam logic [SEL_W-1:0]   SEL_RANDOM   = 3'd7;
    localparam logic [PHASE_W-1:0] PITCH_RESET  = 32'h0001_0000;
    localparam logic [AUDIO_W-1:0] SIGN_FLIP    = 16'h8000;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_LOAD_BYTE = 2'd1,
        OP_LOAD_LEN  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_SELECT = 2'd0,
        REG_PITCH_STEP    = 2'd1,
        REG_HOLD_PERIOD   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // per-tick control that travels beside the sample read
    typedef struct packed {
        logic              plays;
        logic              take;
        logic [FRAC_W-1:0] frac;
    } t_tick_ctl;

    // slot number modulo SLOT_COUNT
    function automatic logic [SEL_W-1:0] slot_reduce(input logic [SEL_W-1:0] sel);
        logic [SEL_W-1:0] v;
        v = sel;
        for (int k = 0; k < 8; k++) begin
            if (32'(v) >= SLOT_COUNT) begin
                v = v - SEL_W'(SLOT_COUNT);
            end
        end
        return v;
    endfunction

endpackage

### src/tsp_ram.sv
module tsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### src/tsp_ctrl.sv
module tsp_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_adv,
    input  logic [tsp_pkg::OP_W-1:0]       i_operation,
    input  logic                           i_gate_rise,
    input  logic [tsp_pkg::SEL_W-1:0]      i_random_slot,
    input  logic [tsp_pkg::SEL_W-1:0]      i_load_slot,
    input  logic [tsp_pkg::LADDR_W-1:0]    i_load_address,
    input  logic [tsp_pkg::LEN_W-1:0]      i_load_value,
    input  tsp_pkg::t_cfg_wr               i_cfg,
    output logic                           o_mem_we,
    output logic [tsp_pkg::ADDR_W-1:0]     o_mem_waddr,
    output logic [tsp_pkg::SAMPLE_W-1:0]   o_mem_wdata,
    output logic [tsp_pkg::ADDR_W-1:0]     o_rd_addr_a,
    output logic [tsp_pkg::ADDR_W-1:0]     o_rd_addr_b,
    output tsp_pkg::t_tick_ctl             o_ctl
);

    import tsp_pkg::*;

    logic [SEL_W-1:0]   r_sample_select;
    logic [PHASE_W-1:0] r_pitch_step;
    logic [HOLD_W-1:0]  r_hold_period;

    logic [PHASE_W-1:0] r_phase;
    logic               r_playing;
    logic [SEL_W-1:0]   r_slot;
    logic [HOLD_W-1:0]  r_hold;
    logic [LEN_W-1:0]   r_len [SLOT_COUNT];
    t_tick_ctl          r_ctl;

    logic               tick;
    logic [SEL_W-1:0]   slot_eff;
    logic [PHASE_W-1:0] phase_eff;
    logic               playing_eff;
    logic [LEN_W-1:0]   len_raw;
    logic [LEN_W-1:0]   len_c;
    logic [INT_W-1:0]   integral;
    logic               plays;
    logic               take;
    logic [PHASE_W-1:0] n_phase;
    logic [HOLD_W-1:0]  n_hold;
    t_tick_ctl          n_ctl;

    assign tick = i_accept && (i_operation == OP_TICK);

    // a rise restarts the phase and picks the slot
    always_comb begin
        if (i_gate_rise) begin
            phase_eff   = '0;
            playing_eff = 1'b1;
            slot_eff    = (r_sample_select != SEL_RANDOM) ? slot_reduce(r_sample_select)
                                                          : slot_reduce(i_random_slot);
        end else begin
            phase_eff   = r_phase;
            playing_eff = r_playing;
            slot_eff    = r_slot;
        end
    end

    assign len_raw  = r_len[slot_eff[SLOT_W-1:0]];
    assign len_c    = (32'(len_raw) > SLOT_BYTES) ? LEN_W'(SLOT_BYTES) : len_raw;
    assign integral = phase_eff[PHASE_W-1:FRAC_W];
    assign plays    = playing_eff && (len_c >= LEN_W'(2))
                      && (32'(integral) < (32'(len_c) - 32'd1));

    assign n_phase = plays ? (phase_eff + r_pitch_step) : phase_eff;

    assign take   = (r_hold == '0);
    assign n_hold = take ? r_hold_period : (r_hold - HOLD_W'(1));

    assign o_rd_addr_a = ADDR_W'(32'(slot_eff) * SLOT_BYTES + 32'(integral));
    assign o_rd_addr_b = o_rd_addr_a + ADDR_W'(1);

    assign o_mem_we    = i_accept && (i_operation == OP_LOAD_BYTE)
                         && (32'(i_load_slot) < SLOT_COUNT)
                         && (32'(i_load_address) < SLOT_BYTES);
    assign o_mem_waddr = ADDR_W'(32'(i_load_slot) * SLOT_BYTES + 32'(i_load_address));
    assign o_mem_wdata = i_load_value[SAMPLE_W-1:0];

    always_comb begin
        n_ctl.plays = plays;
        n_ctl.take  = take;
        n_ctl.frac  = phase_eff[FRAC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_select <= '0;
            r_pitch_step    <= PITCH_RESET;
            r_hold_period   <= '0;
            r_phase         <= '0;
            r_playing       <= 1'b0;
            r_slot          <= '0;
            r_hold          <= '0;
        end else begin
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    REG_SAMPLE_SELECT: r_sample_select <= i_cfg.data[SEL_W-1:0];
                    REG_PITCH_STEP:    r_pitch_step    <= i_cfg.data[PHASE_W-1:0];
                    REG_HOLD_PERIOD:   r_hold_period   <= i_cfg.data[HOLD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (tick) begin
                r_phase   <= n_phase;
                r_playing <= plays;
                r_slot    <= slot_eff;
                r_hold    <= n_hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (i_operation == OP_LOAD_LEN) && (32'(i_load_slot) < SLOT_COUNT)) begin
            r_len[i_load_slot[SLOT_W-1:0]] <= i_load_value;
        end
        if (i_adv) begin
            r_ctl <= n_ctl;
        end
    end

    assign o_ctl = r_ctl;

endmodule

### src/tsp_interp.sv
module tsp_interp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv2,
    input  logic                              i_adv3,
    input  logic                              i_v2,
    input  logic [tsp_pkg::SAMPLE_W-1:0]      i_byte_a,
    input  logic [tsp_pkg::SAMPLE_W-1:0]      i_byte_b,
    input  tsp_pkg::t_tick_ctl                i_ctl,
    output logic signed [tsp_pkg::AUDIO_W-1:0] o_audio_out
);

    import tsp_pkg::*;

    logic [FRAC_W:0]    w_inv;
    logic [PA_W-1:0]    n_pa;
    logic [PB_W-1:0]    n_pb;
    logic [PA_W-1:0]    r_pa;
    logic [PB_W-1:0]    r_pb;
    logic               r_plays;
    logic               r_take;
    logic [PA_W-1:0]    sum;
    logic [AUDIO_W-1:0] v;
    logic [AUDIO_W-1:0] sample;
    logic [AUDIO_W-1:0] r_held;

    // weights 1.0 - f and f
    assign w_inv = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, i_ctl.frac};
    assign n_pa  = PA_W'(i_byte_a) * PA_W'(w_inv);
    assign n_pb  = PB_W'(i_byte_b) * PB_W'(i_ctl.frac);

    always_ff @(posedge i_clk) begin
        if (i_adv2) begin
            r_pa    <= n_pa;
            r_pb    <= n_pb;
            r_plays <= i_ctl.plays;
            r_take  <= i_ctl.take;
        end
    end

    assign sum    = r_pa + PA_W'(r_pb);
    assign v      = sum[AUDIO_W+INTERP_SHIFT-1:INTERP_SHIFT];
    assign sample = r_plays ? (v ^ SIGN_FLIP) : '0;

    // sample-and-hold decimator output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_adv3 && i_v2 && r_take) begin
            r_held <= sample;
        end
    end

    assign o_audio_out = $signed(r_held);

endmodule

### src/triggered_sample_player_unit.sv
// Triggered one-shot sample player with pitch shift, linear interpolation and a
// sample-and-hold decimator.
// Input channel (i_in_valid / o_in_stall): one request per cycle while o_in_stall is low.
// Operation tick yields one audio_out result; the two load operations fill sample bytes
// and slot lengths and yield nothing. Load all bytes and the length of a slot before it plays.
// Output channel (o_out_valid / i_out_stall): a tick's result reaches the output register
// after the RAM read, the products, then sum and hold together in the last stage.
// Throughput is one request per cycle while the output is not stalled, set by the
// dual-read sample RAM which fetches both neighbouring bytes in one access.
// When the receiver stalls, bubbles in the three-stage pipe still fill; o_in_stall
// rises only once all stages hold results. The stall path is combinational.
// Config port (i_cfg_valid / o_cfg_ready, always ready): write only while idle.
// Reset (synchronous, active low) clears phase, play state, slot, hold counter,
// held output and config registers; sample RAM and slot lengths keep no reset.
`include "triggered_sample_player_unit_assert.svh"

module triggered_sample_player_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tsp_pkg::OP_W-1:0]            i_operation,
    input  logic                                i_gate_rise,
    input  logic [tsp_pkg::SEL_W-1:0]           i_random_slot,
    input  logic [tsp_pkg::SEL_W-1:0]           i_load_slot,
    input  logic [tsp_pkg::LADDR_W-1:0]         i_load_address,
    input  logic [tsp_pkg::LEN_W-1:0]           i_load_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tsp_pkg::AUDIO_W-1:0]  o_audio_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tsp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tsp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import tsp_pkg::*;

    // pipe valid flags: stage 1 RAM read, stage 2 products, stage 3 output
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic en1;
    logic en2;
    logic en3;
    logic in_acc;
    logic is_tick;

    t_cfg_wr   cfg;
    t_tick_ctl ctl;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [SAMPLE_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    logic [SAMPLE_W-1:0] byte_a;
    logic [SAMPLE_W-1:0] byte_b;

    // a stage moves on when the next one is empty or moving
    assign en3 = !r_v3 || !i_out_stall;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_stall  = !en1;
    assign in_acc      = i_in_valid && en1;
    assign is_tick     = i_operation == OP_TICK;
    assign o_out_valid = r_v3;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        cfg.we   = i_cfg_valid && o_cfg_ready;
        cfg.idx  = i_cfg_index;
        cfg.data = i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= in_acc && is_tick;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // phase, slot choice, hold counter, config and slot lengths
    tsp_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_acc),
        .i_adv          (en1),
        .i_operation    (i_operation),
        .i_gate_rise    (i_gate_rise),
        .i_random_slot  (i_random_slot),
        .i_load_slot    (i_load_slot),
        .i_load_address (i_load_address),
        .i_load_value   (i_load_value),
        .i_cfg          (cfg),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_rd_addr_a    (rd_addr_a),
        .o_rd_addr_b    (rd_addr_b),
        .o_ctl          (ctl)
    );

    // all slots in one byte RAM, both neighbours read in the same cycle
    tsp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MEM_DEPTH)
    ) u_sample_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (en1),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (byte_a),
        .o_rdata_b (byte_b)
    );

    tsp_interp u_interp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv2      (en2),
        .i_adv3      (en3),
        .i_v2        (r_v2),
        .i_byte_a    (byte_a),
        .i_byte_b    (byte_b),
        .i_ctl       (ctl),
        .o_audio_out (o_audio_out)
    );

    // input only stalls with the whole pipe full and the output held
    `TSP_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall |-> (r_v1 && r_v2 && r_v3 && i_out_stall))
    // loads never enter the result pipe
    `TSP_ASSERT(a_load_no_result, i_clk, i_rst_n, (in_acc && !is_tick) |=> !r_v1)
    // the held sample moves only when a tick leaves stage 2
    `TSP_ASSERT(a_held_stable, i_clk, i_rst_n, !(r_v2 && en3) |=> $stable(o_audio_out))
    // reset empties the output register
    `TSP_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule
